### rtl/core/pbkf_pkg.sv
// ----------------------------------------------------------------------------
// pbkf_pkg
// Shared types, constants and helpers for the pose blend Kalman filter core.
// ----------------------------------------------------------------------------
package pbkf_pkg;

    // Field widths
    localparam int POS_W    = 32;
    localparam int COV_W    = 20;
    localparam int GAIN_W   = 17;
    localparam int DEN_W    = COV_W + 1;
    localparam int NUM_W    = COV_W + 16 + 1;
    localparam int MUL_A_W  = GAIN_W;
    localparam int MUL_B_W  = POS_W + 1;
    localparam int PROD_W   = MUL_A_W + 1 + MUL_B_W;
    localparam int WIDE_W   = PROD_W + 1;
    localparam int SHR_W    = WIDE_W - 16;

    // Divider sizing: one quotient bit per step
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Fixed-point constants
    localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(65536);
    localparam logic [COV_W-1:0]  COV_MAX = {COV_W{1'b1}};
    localparam logic [WIDE_W-1:0] ROUND_HALF = WIDE_W'(32768);

    // Register reset values
    localparam logic [COV_W-1:0]  PROCESS_NOISE_RST  = COV_W'(655);
    localparam logic [COV_W-1:0]  MEASURE_NOISE_RST  = COV_W'(3277);
    localparam logic [GAIN_W-1:0] PRIMARY_WEIGHT_RST = GAIN_W'(45875);
    localparam logic [COV_W-1:0]  COVARIANCE_RST     = COV_W'(6554);

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PROCESS_NOISE  = 2'd0,
        REG_MEASURE_NOISE  = 2'd1,
        REG_PRIMARY_WEIGHT = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_idx_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [SHR_W-1:0] v);
        logic signed [SHR_W-1:0] hi;
        logic signed [SHR_W-1:0] lo;
        hi = SHR_W'(64'sh7FFF_FFFF);
        lo = -SHR_W'(64'sh8000_0000);
        if (v > hi) begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            return v[POS_W-1:0];
        end
    endfunction

endpackage

### rtl/core/pbkf_div.sv
// ----------------------------------------------------------------------------
// pbkf_div
// Restoring divider that forms the Kalman gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbkf_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [pbkf_pkg::NUM_W-1:0]        num,
    input  logic [pbkf_pkg::DEN_W-1:0]        den,
    output logic [pbkf_pkg::GAIN_W-1:0]       quot,
    output pbkf_pkg::div_status_t             status
);

    logic [pbkf_pkg::DEN_W-1:0]     rem_reg;
    logic [pbkf_pkg::DEN_W-1:0]     rem_next;
    logic [pbkf_pkg::DEN_W-1:0]     den_reg;
    logic [pbkf_pkg::GAIN_W-1:0]    low_reg;
    logic [pbkf_pkg::GAIN_W-1:0]    quot_reg;
    logic [pbkf_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [pbkf_pkg::DEN_W:0]       trial;
    logic [pbkf_pkg::DEN_W:0]       diff;
    logic                           fits;

    // One restoring step: shift in the next numerator bit, subtract if it fits.
    always_comb begin
        trial    = {rem_reg, low_reg[pbkf_pkg::GAIN_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[pbkf_pkg::DEN_W-1:0] : trial[pbkf_pkg::DEN_W-1:0];
    end

    // Step sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= pbkf_pkg::DIV_CNT_W'(pbkf_pkg::DIV_STEPS - 1);
                rem_reg  <= {1'b0, num[pbkf_pkg::NUM_W-1:pbkf_pkg::GAIN_W]};
                low_reg  <= num[pbkf_pkg::GAIN_W-1:0];
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                low_reg  <= {low_reg[pbkf_pkg::GAIN_W-2:0], 1'b0};
                quot_reg <= {quot_reg[pbkf_pkg::GAIN_W-2:0], fits};
                cnt_reg  <= cnt_reg - pbkf_pkg::DIV_CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot        = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### rtl/core/pbkf_mul.sv
// ----------------------------------------------------------------------------
// pbkf_mul
// Shared registered multiplier: unsigned 17-bit times signed 33-bit.
// ----------------------------------------------------------------------------
module pbkf_mul (
    input  logic                                aclk,
    input  logic        [pbkf_pkg::MUL_A_W-1:0] op_a,
    input  logic signed [pbkf_pkg::MUL_B_W-1:0] op_b,
    output logic signed [pbkf_pkg::PROD_W-1:0]  prod
);

    logic signed [pbkf_pkg::PROD_W-1:0] prod_reg;
    logic signed [pbkf_pkg::MUL_A_W:0]  a_ext;

    assign a_ext = signed'({1'b0, op_a});

    // The product is registered before any use.
    always_ff @(posedge aclk) begin
        prod_reg <= pbkf_pkg::PROD_W'(a_ext) * pbkf_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

### rtl/core/pose_blend_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// pose_blend_kalman_filter_core
// Blends two localizer positions and runs a two-axis random-walk Kalman filter.
// ----------------------------------------------------------------------------
// An item whose both_valid flag is clear is taken and yields no result. Any
// other item passes from acceptance through these steps in order: predicting
// the variance and starting the divider, the bit-serial gain divider (17
// quotient bits, then taking the gain), the shared multiplier for the two
// blends, the two estimate corrections and the variance update, and loading
// the output register, which waits until that register is free. The block
// accepts a new item as soon as that work is done, even while the last result
// still waits in the output register.
// Results saturate to the signed 32-bit range; the configuration registers sit
// at byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module pose_blend_kalman_filter_core (
    input  logic               aclk,
    input  logic               aresetn,
    // Input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_both_valid,
    input  logic signed [31:0] s_primary_x,
    input  logic signed [31:0] s_primary_y,
    input  logic signed [31:0] s_secondary_x,
    input  logic signed [31:0] s_secondary_y,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_fused_x,
    output logic signed [31:0] m_fused_y,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int POS_W  = pbkf_pkg::POS_W;
    localparam int COV_W  = pbkf_pkg::COV_W;
    localparam int GAIN_W = pbkf_pkg::GAIN_W;
    localparam int DEN_W  = pbkf_pkg::DEN_W;
    localparam int WIDE_W = pbkf_pkg::WIDE_W;
    localparam int SHR_W  = pbkf_pkg::SHR_W;
    localparam int B_W    = pbkf_pkg::MUL_B_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRED,
        S_DSTART,
        S_DIV,
        S_BX,
        S_BY,
        S_CX,
        S_CY,
        S_CV,
        S_CF,
        S_OUT
    } state_t;

    state_t                      state_reg;
    logic [COV_W-1:0]            pn_reg;
    logic [COV_W-1:0]            mn_reg;
    logic [GAIN_W-1:0]           pw_reg;
    logic [COV_W-1:0]            cov_reg;
    logic [COV_W-1:0]            pp_reg;
    logic [COV_W-1:0]            pp_next;
    logic [DEN_W-1:0]            den_reg;
    logic [DEN_W-1:0]            den_next;
    logic [GAIN_W-1:0]           k_reg;
    logic signed [POS_W-1:0]     px_reg;
    logic signed [POS_W-1:0]     py_reg;
    logic signed [POS_W-1:0]     sx_reg;
    logic signed [POS_W-1:0]     sy_reg;
    logic signed [POS_W-1:0]     zx_reg;
    logic signed [POS_W-1:0]     zy_reg;
    logic signed [POS_W-1:0]     ex_reg;
    logic signed [POS_W-1:0]     ey_reg;
    logic signed [POS_W-1:0]     fx_reg;
    logic signed [POS_W-1:0]     fy_reg;
    logic                        m_valid_reg;

    logic [COV_W:0]              pp_sum;
    logic [pbkf_pkg::NUM_W-1:0]  div_num;
    logic                        div_start;
    logic [GAIN_W-1:0]           div_quot;
    pbkf_pkg::div_status_t       div_st;
    logic [GAIN_W-1:0]           weight;
    logic [GAIN_W-1:0]           mul_a;
    logic signed [B_W-1:0]       mul_b;
    logic signed [pbkf_pkg::PROD_W-1:0] mul_prod;
    logic signed [WIDE_W-1:0]    prod_ext;
    logic signed [WIDE_W-1:0]    rnd_sum;
    logic signed [WIDE_W-1:0]    sx_scaled;
    logic signed [WIDE_W-1:0]    sy_scaled;
    logic signed [WIDE_W-1:0]    blend_x_sum;
    logic signed [WIDE_W-1:0]    blend_y_sum;
    logic signed [SHR_W-1:0]     corr_step;
    logic signed [SHR_W-1:0]     ex_sum;
    logic signed [SHR_W-1:0]     ey_sum;
    logic                        cfg_write;
    pbkf_pkg::reg_idx_t          cfg_idx;

    // Configuration port decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = pbkf_pkg::reg_idx_t'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            pbkf_pkg::REG_PROCESS_NOISE:  prdata = {12'd0, pn_reg};
            pbkf_pkg::REG_MEASURE_NOISE:  prdata = {12'd0, mn_reg};
            pbkf_pkg::REG_PRIMARY_WEIGHT: prdata = {15'd0, pw_reg};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_reg <= pbkf_pkg::PROCESS_NOISE_RST;
            mn_reg <= pbkf_pkg::MEASURE_NOISE_RST;
            pw_reg <= pbkf_pkg::PRIMARY_WEIGHT_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                pbkf_pkg::REG_PROCESS_NOISE:  pn_reg <= pwdata[COV_W-1:0];
                pbkf_pkg::REG_MEASURE_NOISE:  mn_reg <= pwdata[COV_W-1:0];
                pbkf_pkg::REG_PRIMARY_WEIGHT: pw_reg <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Variance prediction, saturated, and the gain denominator
    always_comb begin
        pp_sum   = {1'b0, cov_reg} + {1'b0, pn_reg};
        pp_next  = pp_sum[COV_W] ? pbkf_pkg::COV_MAX : pp_sum[COV_W-1:0];
        den_next = {1'b0, pp_next} + {1'b0, mn_reg};
        div_num  = {1'b0, pp_reg, 16'd0} + {17'd0, den_reg[DEN_W-1:1]};
    end

    assign div_start = (state_reg == S_DSTART);

    pbkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_reg),
        .quot    (div_quot),
        .status  (div_st)
    );

    // Operand selection for the shared multiplier
    assign weight = (pw_reg > pbkf_pkg::ONE_Q16) ? pbkf_pkg::ONE_Q16 : pw_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_BX: begin
                mul_a = weight;
                mul_b = {px_reg[POS_W-1], px_reg} - {sx_reg[POS_W-1], sx_reg};
            end
            S_BY: begin
                mul_a = weight;
                mul_b = {py_reg[POS_W-1], py_reg} - {sy_reg[POS_W-1], sy_reg};
            end
            S_CX: begin
                mul_a = k_reg;
                mul_b = {zx_reg[POS_W-1], zx_reg} - {ex_reg[POS_W-1], ex_reg};
            end
            S_CY: begin
                mul_a = k_reg;
                mul_b = {zy_reg[POS_W-1], zy_reg} - {ey_reg[POS_W-1], ey_reg};
            end
            S_CV: begin
                mul_a = pbkf_pkg::ONE_Q16 - k_reg;
                mul_b = signed'({(B_W-COV_W)'(0), pp_reg});
            end
            default: ;
        endcase
    end

    pbkf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // Post-processing of the registered product
    always_comb begin
        prod_ext    = {mul_prod[pbkf_pkg::PROD_W-1], mul_prod};
        rnd_sum     = prod_ext + signed'(pbkf_pkg::ROUND_HALF);
        sx_scaled   = {{(WIDE_W-POS_W-16){sx_reg[POS_W-1]}}, sx_reg, 16'd0};
        sy_scaled   = {{(WIDE_W-POS_W-16){sy_reg[POS_W-1]}}, sy_reg, 16'd0};
        blend_x_sum = sx_scaled + rnd_sum;
        blend_y_sum = sy_scaled + rnd_sum;
        corr_step   = rnd_sum[WIDE_W-1:16];
        ex_sum      = {{(SHR_W-POS_W){ex_reg[POS_W-1]}}, ex_reg} + corr_step;
        ey_sum      = {{(SHR_W-POS_W){ey_reg[POS_W-1]}}, ey_reg} + corr_step;
    end

    // Sequencer with filter state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            cov_reg     <= pbkf_pkg::COVARIANCE_RST;
            ex_reg      <= '0;
            ey_reg      <= '0;
        end else begin
            // A taken result clears the output unless a new one is loaded now.
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        px_reg <= s_primary_x;
                        py_reg <= s_primary_y;
                        sx_reg <= s_secondary_x;
                        sy_reg <= s_secondary_y;
                        if (s_both_valid) begin
                            state_reg <= S_PRED;
                        end
                    end
                end
                S_PRED: begin
                    pp_reg    <= pp_next;
                    den_reg   <= den_next;
                    state_reg <= S_DSTART;
                end
                S_DSTART: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_st.done) begin
                        k_reg     <= (den_reg == '0) ? '0 : div_quot;
                        state_reg <= S_BX;
                    end
                end
                S_BX: begin
                    state_reg <= S_BY;
                end
                S_BY: begin
                    zx_reg    <= pbkf_pkg::sat32(blend_x_sum[WIDE_W-1:16]);
                    state_reg <= S_CX;
                end
                S_CX: begin
                    zy_reg    <= pbkf_pkg::sat32(blend_y_sum[WIDE_W-1:16]);
                    state_reg <= S_CY;
                end
                S_CY: begin
                    ex_reg    <= pbkf_pkg::sat32(ex_sum);
                    state_reg <= S_CV;
                end
                S_CV: begin
                    ey_reg    <= pbkf_pkg::sat32(ey_sum);
                    state_reg <= S_CF;
                end
                S_CF: begin
                    cov_reg   <= rnd_sum[COV_W+15:16];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // Wait until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        fx_reg      <= ex_reg;
                        fy_reg      <= ey_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_fused_x = fx_reg;
    assign m_fused_y = fy_reg;

`ifndef SYNTHESIS
    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == S_DIV))
        else $error("gain divider finished outside its wait state");

    // No item is taken while the divider is working.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.busy |-> !s_ready)
        else $error("input ready while gain division is running");

    // The gain never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CX || state_reg == S_CY || state_reg == S_CV)
            |-> (k_reg <= pbkf_pkg::ONE_Q16))
        else $error("Kalman gain above one");

    // A newly offered result carries the current estimates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (fx_reg == ex_reg && fy_reg == ey_reg))
        else $error("offered result differs from the filter estimates");
`endif

endmodule
